>>> src/ovsc_pkg.sv
package ovsc_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int LINE_BUFFER     = 1000;
  localparam int PAT_HALF_BYTES  = 8;

  localparam int DATA_W   = 8;
  localparam int LEN_REG_W = 5;
  localparam int LIMIT_W  = 12;
  localparam int COUNT_W  = 32;
  localparam int APB_W    = 64;
  localparam int ADDR_W   = 5;
  localparam int REG_IDX_W = 2;

  localparam logic [DATA_W-1:0]    NEWLINE_BYTE    = 8'h0A;
  localparam logic [DATA_W-1:0]    ZERO_BYTE       = 8'h00;
  localparam logic [LEN_REG_W-1:0] PATTERN_LEN_RST = 5'd1;
  localparam logic [LIMIT_W-1:0]   CHUNK_LIMIT_RST = LIMIT_W'(LINE_BUFFER - 1);
  localparam logic [COUNT_W-1:0]   COUNT_MAX       = '1;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LO = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HI = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CHUNK_LIMIT = 2'd3;

  typedef logic [DATA_W-1:0] byte_t;

endpackage

>>> src/overlapping_substring_counter.sv
// overlapping substring counter
// input channel: one file byte per transfer (in_data_byte) with in_end_of_file
// set on the last byte of the file. result channel: one transfer per file,
// out_match_total, the saturating count of all pattern start positions,
// overlaps included. matches never span a chunk; a chunk ends after a
// newline byte or after chunk_limit bytes, and a zero byte hides the rest
// of its chunk.
// the pattern (up to 16 bytes), its length and the chunk limit sit in four
// 64-bit apb registers at byte addresses 0, 8, 16 and 24; write them while
// no file is in flight.
// throughput: one byte per cycle while in_stall is low; the window compare and the
// count update are combinational behind the input register.
// the end-of-file byte passes the input register and then the result register,
// which offers the file's count on out_match_total.
// reset clears the stream state, the pipeline valids and the registers to
// their defaults (pattern zero, length 1, chunk limit 999); the end of a file
// clears the stream state as well.
// a stall on the result channel holds the finished count; bytes keep flowing
// until an end-of-file byte needs the output register, then in_stall rises.
module overlapping_substring_counter #(
  parameter int MAX_PATTERN = ovsc_pkg::MAX_PATTERN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ovsc_pkg::DATA_W-1:0]   in_data_byte,
  input  logic                          in_end_of_file,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ovsc_pkg::COUNT_W-1:0]  out_match_total,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ovsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [ovsc_pkg::APB_W-1:0]    pwdata,
  output logic [ovsc_pkg::APB_W-1:0]    prdata,
  output logic                          pready
);
  import ovsc_pkg::*;

  localparam int LEN_W = ($clog2(MAX_PATTERN + 1) < LEN_REG_W) ? LEN_REG_W
                                                                 : $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int N_W   = LIMIT_W + 1;

  // configuration registers
  logic [APB_W-1:0]     pattern_lo_r, pattern_hi_r;
  logic [LEN_REG_W-1:0] pattern_len_r;
  logic [LIMIT_W-1:0]   chunk_limit_r;
  logic [REG_IDX_W-1:0] reg_idx;

  // input register
  logic                 in_vld_r;
  byte_t                in_byte_r;
  logic                 in_eof_r;

  // stream state
  byte_t                recent_r [MAX_PATTERN];
  byte_t                win      [MAX_PATTERN];
  logic [LIMIT_W-1:0]   bytes_in_chunk_r;
  logic                 chunk_hidden_r;
  logic [COUNT_W-1:0]   count_r, count_nxt;

  // output register
  logic                 out_vld_r;
  logic [COUNT_W-1:0]   out_total_r;

  byte_t                pat [MAX_PATTERN];
  logic [LEN_W-1:0]     len_ext, len_eff;
  logic [N_W-1:0]       n;
  logic                 hidden, hit, boundary;
  logic                 out_free, advance, take_in;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_lo_r  <= '0;
      pattern_hi_r  <= '0;
      pattern_len_r <= PATTERN_LEN_RST;
      chunk_limit_r <= CHUNK_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_PATTERN_LO:  pattern_lo_r  <= pwdata;
        REG_PATTERN_HI:  pattern_hi_r  <= pwdata;
        REG_PATTERN_LEN: pattern_len_r <= pwdata[LEN_REG_W-1:0];
        REG_CHUNK_LIMIT: chunk_limit_r <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN_LO:  prdata = pattern_lo_r;
      REG_PATTERN_HI:  prdata = pattern_hi_r;
      REG_PATTERN_LEN: prdata = APB_W'(pattern_len_r);
      REG_CHUNK_LIMIT: prdata = APB_W'(chunk_limit_r);
      default:         prdata = '0;
    endcase
  end

  // handshake
  assign out_free = !out_vld_r || !out_stall;
  assign advance  = in_vld_r && (!in_eof_r || out_free);
  assign in_stall = in_vld_r && !advance;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_byte_r <= in_data_byte;
      in_eof_r  <= in_end_of_file;
    end
  end

  // pattern bytes, zero past the two halves
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k < PAT_HALF_BYTES) begin
        pat[k] = pattern_lo_r[8*k +: 8];
      end else if (k < 2*PAT_HALF_BYTES) begin
        pat[k] = pattern_hi_r[8*(k-PAT_HALF_BYTES) +: 8];
      end else begin
        pat[k] = ZERO_BYTE;
      end
    end
  end

  // window with the new byte at index 0
  always_comb begin
    win[0] = in_byte_r;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win[j] = recent_r[j-1];
    end
  end

  always_comb begin
    len_ext = LEN_W'(pattern_len_r);
    if (len_ext == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_ext > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_ext;
    end
  end

  // pattern byte k lines up with window slot len-1-k
  always_comb begin
    logic [LEN_W-1:0] diff;
    hit  = 1'b1;
    diff = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (LEN_W'(k) < len_eff) begin
        diff = len_eff - LEN_W'(1) - LEN_W'(k);
        if (win[diff[IDX_W-1:0]] != pat[k]) begin
          hit = 1'b0;
        end
      end
    end
  end

  assign hidden   = chunk_hidden_r || (in_byte_r == ZERO_BYTE);
  assign n        = N_W'(bytes_in_chunk_r) + N_W'(1);
  assign boundary = (in_byte_r == NEWLINE_BYTE) || (n >= N_W'(chunk_limit_r));

  always_comb begin
    count_nxt = count_r;
    if (!hidden && (n >= N_W'(len_eff)) && hit && (count_r != COUNT_MAX)) begin
      count_nxt = count_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        recent_r[j] <= ZERO_BYTE;
      end
      bytes_in_chunk_r <= '0;
      chunk_hidden_r   <= 1'b0;
      count_r          <= '0;
    end else if (advance) begin
      if (in_eof_r) begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
          recent_r[j] <= ZERO_BYTE;
        end
        bytes_in_chunk_r <= '0;
        chunk_hidden_r   <= 1'b0;
        count_r          <= '0;
      end else begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
          recent_r[j] <= win[j];
        end
        bytes_in_chunk_r <= boundary ? '0 : n[LIMIT_W-1:0];
        chunk_hidden_r   <= boundary ? 1'b0 : hidden;
        count_r          <= count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= advance && in_eof_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_eof_r) begin
      out_total_r <= count_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_match_total = out_total_r;

endmodule
